// ----- design/oes_pkg.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering package
// Shared types, constants and command/status structs.
// ----------------------------------------------------------------------------
package oes_pkg;

    localparam int HISTORY_DEPTH   = 4;
    localparam int IMAGE_WIDTH     = 176;
    localparam int IMAGE_HEIGHT    = 144;
    localparam int RECTS_PER_FRAME = 8;

    localparam logic signed [15:0] Q_STEP_BASE = 16'sd1408;
    localparam logic signed [15:0] Q_DEAD_ZONE = 16'sd896;
    localparam logic signed [15:0] Q_RECENTER  = 16'sd1152;

    localparam logic [2:0] REG_CAR_WIDTH     = 3'd0;
    localparam logic [2:0] REG_WINDOW_TOP    = 3'd1;
    localparam logic [2:0] REG_DISTANCE_CAP  = 3'd2;
    localparam logic [2:0] REG_TURN_LIMIT    = 3'd3;
    localparam logic [2:0] REG_CRUISE_SPEED  = 3'd4;
    localparam logic [2:0] REG_TURNING_SPEED = 3'd5;

    typedef struct packed {
        logic       rect_present;
        logic [7:0] rect_left;
        logic [7:0] rect_top;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic              collides;
        logic [7:0]        wall_distance;
        logic              advice_valid;
        logic [6:0]        advised_speed;
        logic signed [7:0] advised_angle;
    } out_item_t;

    typedef struct packed {
        logic [7:0] car_width;
        logic [7:0] window_top;
        logic [7:0] distance_cap;
        logic [6:0] turn_limit;
        logic [6:0] cruise_speed;
        logic [6:0] turning_speed;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic sqrt_start; // start root / prepare
        logic rect_done;  // commit rectangle results
        logic div_start;  // start step division
        logic div_step;   // one quotient bit
        logic sqrt_step;  // one root step
        logic finish;     // form advice, load output
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic frame_end;
    } sts_t;

endpackage

// ----- design/oes_ctrl.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering controller
// Sequences load, root, division (frame end only) and advice steps for one item.
// ----------------------------------------------------------------------------
module oes_ctrl
    import oes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_free,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_ROOT = 6'b000100,
        S_DIVS = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (sts.sqrt_busy)
                    cmd.sqrt_step = 1'b1;
                else
                begin
                    cmd.rect_done = 1'b1;
                    state_next    = sts.frame_end ? S_DIVS : S_FIN;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_busy)
                    cmd.div_step = 1'b1;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- design/oes_dp.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering datapath
// Overlap test, serial integer root, serial divider and angle update.
// ----------------------------------------------------------------------------
module oes_dp
    import oes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t res
);

    localparam int MID = IMAGE_WIDTH / 2;

    in_item_t item_reg;

    logic [3:0]        rects_seen_reg;
    logic              wall_found_reg;
    logic [7:0]        nearest_bottom_reg;
    logic signed [7:0] nearest_offset_reg;
    logic [7:0]        nearest_distance_reg;
    logic signed [7:0] hist_reg [HISTORY_DEPTH];
    logic signed [9:0] offset_sum_reg;
    logic signed [15:0] steer_angle_reg;
    logic signed [15:0] previous_angle_reg;

    // per-item rectangle results
    logic       hit_reg;
    logic       direct_reg;
    logic [7:0] direct_dist_reg;
    logic [7:0] rdist_reg;

    // root unit
    logic [17:0] rv_reg;
    logic [17:0] rr_reg;
    logic [17:0] rbit_reg;

    // divider unit
    logic [15:0] dnum_reg;
    logic [8:0]  drem_reg;
    logic [15:0] dq_reg;
    logic [7:0]  dden_reg;
    logic [4:0]  dcnt_reg;
    logic        unb_reg;

    // -------- combinational rectangle geometry
    logic signed [10:0] x, y, w, h, bottom, cx, cwid, x2, dx, dy;
    logic               overlap, spans;
    logic [17:0]        sq_sum;
    logic [7:0]         sb;
    logic signed [10:0] twice;
    logic signed [9:0]  half;
    logic signed [7:0]  off_sat;
    logic signed [10:0] direct_raw;

    always_comb
    begin
        x      = 11'(item_reg.rect_left);
        y      = 11'(item_reg.rect_top);
        w      = 11'(item_reg.rect_width);
        h      = 11'(item_reg.rect_height);
        bottom = y + h;
        cwid   = 11'(cfg.car_width);
        cx     = 11'(MID) - 11'(cfg.car_width >> 1);
        overlap = item_reg.rect_present && (rects_seen_reg < 4'(RECTS_PER_FRAME)) &&
                  (x <= cx + cwid) && (cx <= x + w) &&
                  (y <= 11'(IMAGE_HEIGHT)) && (11'(cfg.window_top) <= bottom);
        spans  = (x <= 11'(MID)) && (x + w >= 11'(MID));
        x2     = (11'(MID) > x + w) ? x + w : x;
        dx     = x2 - 11'(MID);
        dy     = bottom - 11'(IMAGE_HEIGHT);
        sq_sum = 18'(22'(dx) * 22'(dx) + 22'(dy) * 22'(dy));
        direct_raw = 11'(IMAGE_HEIGHT) - bottom;
        sb     = (bottom > 11'sd255) ? 8'd255 : bottom[7:0];
        twice  = 11'(2 * MID) - 11'(2) * x - w;
        half   = 10'(twice / 11'sd2);
        if (half > 10'sd127)
            off_sat = 8'sd127;
        else if (half < -10'sd128)
            off_sat = -8'sd128;
        else
            off_sat = half[7:0];
    end

    assign sts.sqrt_busy = (rbit_reg != '0);
    assign sts.div_busy  = (dcnt_reg != '0);
    assign sts.frame_end = item_reg.frame_end;

    // -------- frame advice logic
    logic signed [7:0]  cur;
    logic signed [9:0]  sum_next;
    logic signed [17:0] lim, a, step, a_sat;
    logic [7:0]         dmin;

    always_comb
    begin
        dmin = (nearest_distance_reg > cfg.distance_cap) ? cfg.distance_cap
                                                          : nearest_distance_reg;
        cur      = wall_found_reg ? nearest_offset_reg : 8'sd0;
        sum_next = offset_sum_reg + 10'(cur) - 10'(hist_reg[0]);
        lim      = 18'({cfg.turn_limit, 8'd0});
        step     = 18'(Q_STEP_BASE) + (wall_found_reg ? 18'(dq_reg) : 18'sd0);
        a        = 18'(steer_angle_reg);
        if (sum_next > -10'(HISTORY_DEPTH) && sum_next < 10'(HISTORY_DEPTH))
        begin
            if (a > -18'(Q_DEAD_ZONE) && a < 18'(Q_DEAD_ZONE))
                a = '0;
            else if (a > 0)
                a = a - 18'(Q_RECENTER);
            else
                a = a + 18'(Q_RECENTER);
        end
        else if (sum_next < 0)
            a = (wall_found_reg && unb_reg) ? -lim : a - step;
        else
            a = (wall_found_reg && unb_reg) ? lim : a + step;
        if (a > lim)
            a_sat = lim;
        else if (a < -lim)
            a_sat = -lim;
        else
            a_sat = a;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.sqrt_start)
        begin
            hit_reg         <= overlap;
            direct_reg      <= spans;
            direct_dist_reg <= (direct_raw < 0) ? 8'd0 :
                               (direct_raw > 11'sd255) ? 8'd255 : direct_raw[7:0];
        end
        if (cmd.div_start)
        begin
            dnum_reg <= {cfg.distance_cap, 8'd0};
            dden_reg <= dmin;
            drem_reg <= '0;
            dq_reg   <= '0;
            unb_reg  <= (dmin == 8'd0);
        end
        else if (cmd.div_step)
        begin
            // restoring division, one quotient bit a cycle
            logic [8:0] t;
            t = {drem_reg[7:0], dnum_reg[15]};
            if (t >= {1'b0, dden_reg})
            begin
                drem_reg <= t - {1'b0, dden_reg};
                dq_reg   <= {dq_reg[14:0], 1'b1};
            end
            else
            begin
                drem_reg <= t;
                dq_reg   <= {dq_reg[14:0], 1'b0};
            end
            dnum_reg <= {dnum_reg[14:0], 1'b0};
        end
    end

    // root unit: start bit fixed at the highest power of four of the 18-bit value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbit_reg <= '0;
            dcnt_reg <= '0;
            rv_reg   <= '0;
            rr_reg   <= '0;
        end
        else
        begin
            if (cmd.sqrt_start)
            begin
                rv_reg   <= sq_sum;
                rr_reg   <= '0;
                rbit_reg <= 18'h10000;
            end
            else if (cmd.sqrt_step)
            begin
                if (rv_reg >= rr_reg + rbit_reg)
                begin
                    rv_reg <= rv_reg - (rr_reg + rbit_reg);
                    rr_reg <= (rr_reg >> 1) + rbit_reg;
                end
                else
                    rr_reg <= rr_reg >> 1;
                rbit_reg <= rbit_reg >> 2;
            end
            if (cmd.div_start)
                dcnt_reg <= 5'd16;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    logic [7:0] dist_now;
    assign dist_now = direct_reg ? direct_dist_reg :
                      ((rr_reg > 18'd255) ? 8'd255 : rr_reg[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rects_seen_reg       <= '0;
            wall_found_reg       <= 1'b0;
            nearest_bottom_reg   <= '0;
            nearest_offset_reg   <= '0;
            nearest_distance_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
            offset_sum_reg     <= '0;
            steer_angle_reg    <= '0;
            previous_angle_reg <= '0;
            rdist_reg          <= '0;
            res                <= '0;
        end
        else
        begin
            if (cmd.rect_done)
            begin
                rdist_reg <= hit_reg ? dist_now : 8'd0;
                if (item_reg.rect_present && rects_seen_reg < 4'(RECTS_PER_FRAME))
                    rects_seen_reg <= rects_seen_reg + 4'd1;
                if (hit_reg && nearest_bottom_reg < sb)
                begin
                    nearest_bottom_reg   <= sb;
                    nearest_distance_reg <= dist_now;
                    nearest_offset_reg   <= off_sat;
                    wall_found_reg       <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                res.collides      <= hit_reg;
                res.wall_distance <= rdist_reg;
                res.advice_valid  <= item_reg.frame_end;
                res.advised_speed <= '0;
                res.advised_angle <= '0;
                if (item_reg.frame_end)
                begin
                    offset_sum_reg <= sum_next;
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                        hist_reg[i] <= hist_reg[i + 1];
                    hist_reg[HISTORY_DEPTH - 1] <= cur;
                    steer_angle_reg <= a_sat[15:0];
                    if (previous_angle_reg != a_sat[15:0])
                    begin
                        previous_angle_reg <= a_sat[15:0];
                        res.advised_speed  <= cfg.turning_speed;
                    end
                    else
                        res.advised_speed <= cfg.cruise_speed;
                    res.advised_angle <= 8'(a_sat / 18'sd256);
                    rects_seen_reg       <= '0;
                    wall_found_reg       <= 1'b0;
                    nearest_bottom_reg   <= '0;
                    nearest_offset_reg   <= '0;
                    nearest_distance_reg <= '0;
                end
            end
        end
    end

endmodule

// ----- design/obstacle_evade_steering_top.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering top level
// Collision test per rectangle and steering advice per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one rectangle or frame end per
//   transfer; output channel out_valid/out_ready returns one result per item.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Operation:
//   Each item is loaded, runs the 9-step serial root, on a frame end also
//   the 16-step serial divider, and then forms its result; one item is in
//   work at a time, so no new item is taken until the last one has formed
//   its result.
// Reset:
//   rst_n clears per-frame state, history, steering angle and registers
//   to their defaults; no output is valid.
// Stall:
//   A finished result sits in the output register; the next item is taken
//   and worked on, and waits before its own result until the register frees.
// ----------------------------------------------------------------------------
module obstacle_evade_steering_top
    import oes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [2:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic out_valid_reg;
    logic out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.car_width     <= 8'd105;
            cfg_reg.window_top    <= 8'd30;
            cfg_reg.distance_cap  <= 8'd60;
            cfg_reg.turn_limit    <= 7'd38;
            cfg_reg.cruise_speed  <= 7'd37;
            cfg_reg.turning_speed <= 7'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CAR_WIDTH:     cfg_reg.car_width     <= cfg_wdata;
                REG_WINDOW_TOP:    cfg_reg.window_top    <= cfg_wdata;
                REG_DISTANCE_CAP:  cfg_reg.distance_cap  <= cfg_wdata;
                REG_TURN_LIMIT:    cfg_reg.turn_limit    <= cfg_wdata[6:0];
                REG_CRUISE_SPEED:  cfg_reg.cruise_speed  <= cfg_wdata[6:0];
                REG_TURNING_SPEED: cfg_reg.turning_speed <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    oes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    oes_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .res     (out_data)
    );

endmodule

// ----- design/oes_checker.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering checker
// Port-level properties of the result channel.
// ----------------------------------------------------------------------------
module oes_checker
    import oes_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no distance without a collision
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.collides |-> out_data.wall_distance == 8'd0)
        else $error("distance without collision");

    // advice fields are zero off frame end
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.advice_valid |->
            out_data.advised_speed == 7'd0 && out_data.advised_angle == 8'sd0)
        else $error("advice outside frame end");

    // a transfer in is followed by no new transfer in next cycle
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

endmodule

bind obstacle_evade_steering_top oes_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- verif/obstacle_evade_steering_top_tb.sv -----
// ----------------------------------------------------------------------------
// Obstacle evade steering testbench
// Drives rectangles and frame ends with random idling on both channels and
// checks every result against an in-bench steering predictor.
// ----------------------------------------------------------------------------
module obstacle_evade_steering_top_tb;
    import oes_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic [2:0] cfg_addr;
    logic [7:0] cfg_wdata;

    obstacle_evade_steering_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    localparam int STALL_LIMIT = 20000;

    // predictor state
    int cw, wtop, dcap, tlim, cspeed, tspeed;
    int seen_cnt;
    bit wall_hit;
    int near_bot, near_off, near_dist;
    int off_hist[HISTORY_DEPTH];
    int off_total;
    int angle_q8, last_angle_q8;

    out_item_t pending_results[$];
    int  fail_cnt;
    int  idle_pct;
    int  stall_cnt;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int int_root(longint v);
        int r;
        r = 0;
        while ((longint'(r + 1) * (r + 1)) <= v)
            r++;
        return r;
    endfunction

    function automatic int span_distance(int x, int w, int bot);
        int mid, x2, dx, dy;
        mid = IMAGE_WIDTH / 2;
        if (x <= mid && x + w >= mid)
            return clip(IMAGE_HEIGHT - bot, 0, 255);
        x2 = (mid > x + w) ? x + w : x;
        dx = x2 - mid;
        dy = bot - IMAGE_HEIGHT;
        return clip(int_root(longint'(dx * dx + dy * dy)), 0, 255);
    endfunction

    function automatic void clear_frame_state();
        seen_cnt  = 0;
        wall_hit  = 1'b0;
        near_bot  = 0;
        near_off  = 0;
        near_dist = 0;
    endfunction

    function automatic void reset_steering();
        cw = 105; wtop = 30; dcap = 60; tlim = 38; cspeed = 37; tspeed = 20;
        clear_frame_state();
        foreach (off_hist[i]) off_hist[i] = 0;
        off_total = 0;
        angle_q8 = 0;
        last_angle_q8 = 0;
    endfunction

    function automatic out_item_t predict_steering(in_item_t it);
        out_item_t r;
        int x, y, w, h, cx, bot, d, sb, cur, lim, a, stp, dd;
        bit unb;
        r = '0;
        if (it.rect_present && seen_cnt < RECTS_PER_FRAME)
        begin
            x = it.rect_left; y = it.rect_top; w = it.rect_width; h = it.rect_height;
            cx = IMAGE_WIDTH / 2 - cw / 2;
            bot = y + h;
            seen_cnt++;
            if (x <= cx + cw && cx <= x + w && y <= IMAGE_HEIGHT && wtop <= bot)
            begin
                d = span_distance(x, w, bot);
                sb = clip(bot, 0, 255);
                r.collides = 1'b1;
                r.wall_distance = d[7:0];
                if (near_bot < sb)
                begin
                    near_bot = sb;
                    near_dist = d;
                    near_off = clip((2 * (IMAGE_WIDTH / 2) - 2 * x - w) / 2, -128, 127);
                    wall_hit = 1'b1;
                end
            end
        end
        if (it.frame_end)
        begin
            cur = wall_hit ? near_off : 0;
            lim = tlim * 256;
            a = angle_q8;
            stp = Q_STEP_BASE;
            unb = 1'b0;
            off_total += cur - off_hist[0];
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) off_hist[i] = off_hist[i + 1];
            off_hist[HISTORY_DEPTH - 1] = cur;
            if (wall_hit)
            begin
                dd = near_dist > dcap ? dcap : near_dist;
                if (dd == 0) unb = 1'b1;
                else stp += (dcap * 256) / dd;
            end
            if (off_total > -HISTORY_DEPTH && off_total < HISTORY_DEPTH)
            begin
                if (a > -Q_DEAD_ZONE && a < Q_DEAD_ZONE) a = 0;
                else if (a > 0) a -= Q_RECENTER;
                else a += Q_RECENTER;
            end
            else if (off_total < 0)
            begin
                a = unb ? -lim : a - stp;
            end
            else
            begin
                a = unb ? lim : a + stp;
            end
            a = clip(a, -lim, lim);
            angle_q8 = a;
            if (last_angle_q8 != angle_q8)
            begin
                last_angle_q8 = angle_q8;
                r.advised_speed = tspeed[6:0];
            end
            else
            begin
                r.advised_speed = cspeed[6:0];
            end
            r.advice_valid = 1'b1;
            r.advised_angle = 8'(angle_q8 / 256);
            clear_frame_state();
        end
        return r;
    endfunction

    // valid drops only while idling or draining, never right after a transfer
    task automatic send_item(in_item_t it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pending_results.push_back(predict_steering(it));
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 8'(val);
        @(posedge clk);
        case (idx)
            REG_CAR_WIDTH:     cw     = val & 8'hFF;
            REG_WINDOW_TOP:    wtop   = val & 8'hFF;
            REG_DISTANCE_CAP:  dcap   = val & 8'hFF;
            REG_TURN_LIMIT:    tlim   = val & 8'h7F;
            REG_CRUISE_SPEED:  cspeed = val & 8'h7F;
            REG_TURNING_SPEED: tspeed = val & 8'h7F;
            default: ;
        endcase
    endtask

    task automatic set_regs(int a, int b, int c, int d, int e, int f);
        wait_drained();
        write_reg(REG_CAR_WIDTH, a);
        write_reg(REG_WINDOW_TOP, b);
        write_reg(REG_DISTANCE_CAP, c);
        write_reg(REG_TURN_LIMIT, d);
        write_reg(REG_CRUISE_SPEED, e);
        write_reg(REG_TURNING_SPEED, f);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t make_rect(int x, int y, int w, int h, bit fe);
        in_item_t it;
        it.rect_present = 1'b1;
        it.rect_left    = 8'(x);
        it.rect_top     = 8'(y);
        it.rect_width   = 8'(w);
        it.rect_height  = 8'(h);
        it.frame_end    = fe;
        return it;
    endfunction

    function automatic in_item_t rand_item(bit fe);
        in_item_t it;
        it.rect_left    = 8'($urandom_range(175));
        it.rect_top     = 8'($urandom_range(143));
        it.rect_width   = 8'($urandom_range(176, 1));
        it.rect_height  = 8'($urandom_range(144, 1));
        it.rect_present = ($urandom_range(9) != 0);
        it.frame_end    = fe;
        // occasionally stress every bit, outside the nominal ranges
        if ($urandom_range(19) == 0)
        begin
            it.rect_left   = 8'($urandom);
            it.rect_top    = 8'($urandom);
            it.rect_width  = 8'($urandom);
            it.rect_height = 8'($urandom);
        end
        return it;
    endfunction

    task automatic test_directed();
        in_item_t bare;
        bare = '0;
        bare.frame_end = 1'b1;
        send_item(bare);
        send_item(make_rect(0, 0, 1, 1, 1'b0));
        send_item(make_rect(175, 143, 176, 144, 1'b0));
        send_item(make_rect(80, 100, 20, 44, 1'b1));       // spans center, zero distance
        send_item(make_rect(20, 50, 30, 40, 1'b0));        // left of center
        send_item(make_rect(120, 50, 40, 60, 1'b1));       // right of center, bottom inside the image
        for (int i = 0; i < 10; i++)                       // more than the per-frame limit
            send_item(make_rect(40 + i, 60, 20, 30, i == 9));
        send_item(make_rect(10, 20, 50, 100, 1'b1));
        send_item(make_rect(10, 20, 50, 100, 1'b1));
        send_item(make_rect(130, 30, 40, 80, 1'b1));
        send_item(bare);
        send_item(bare);
    endtask

    task automatic test_random(int n);
        int cnt, k;
        cnt = 0;
        while (cnt < n)
        begin
            k = $urandom_range(RECTS_PER_FRAME + 2);
            for (int i = 0; i < k; i++)
            begin
                send_item(rand_item(1'b0));
                cnt++;
            end
            send_item(rand_item($urandom_range(3) != 0 ? 1'b1 : 1'b0));
            cnt++;
        end
    endtask

    task automatic test_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        test_random(120);
        idle_pct = 35;
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                fail_cnt++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_data.collides !== exp_r.collides)
                begin
                    $error("collides exp %0d got %0d", exp_r.collides, out_data.collides);
                    fail_cnt++;
                end
                if (out_data.wall_distance !== exp_r.wall_distance)
                begin
                    $error("wall_distance exp %0d got %0d",
                           exp_r.wall_distance, out_data.wall_distance);
                    fail_cnt++;
                end
                if (out_data.advice_valid !== exp_r.advice_valid)
                begin
                    $error("advice_valid exp %0d got %0d",
                           exp_r.advice_valid, out_data.advice_valid);
                    fail_cnt++;
                end
                if (out_data.advised_speed !== exp_r.advised_speed)
                begin
                    $error("advised_speed exp %0d got %0d",
                           exp_r.advised_speed, out_data.advised_speed);
                    fail_cnt++;
                end
                if (out_data.advised_angle !== exp_r.advised_angle)
                begin
                    $error("advised_angle exp %0d got %0d",
                           exp_r.advised_angle, out_data.advised_angle);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver idling
    always @(posedge clk)
    begin
        if (idle_pct == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on lack of transfers
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        fail_cnt  = 0;
        idle_pct  = 35;
        reset_steering();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200);
        set_regs(176, 0, 255, 90, 127, 0);
        test_directed();
        test_random(120);
        set_regs(1, 143, 1, 1, 0, 127);
        test_directed();
        test_random(120);
        set_regs(60, 70, 20, 0, 5, 9);
        test_random(60);
        set_regs($urandom_range(176, 1), $urandom_range(143), $urandom_range(255, 1),
                 $urandom_range(90, 1), $urandom_range(127), $urandom_range(127));
        test_pause();
        test_no_idle();
        test_random(150);

        wait_drained();
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- obstacle_evade_steering_top.f -----
design/oes_pkg.sv
design/oes_ctrl.sv
design/oes_dp.sv
design/obstacle_evade_steering_top.sv
design/oes_checker.sv
verif/obstacle_evade_steering_top_tb.sv
